@@ src/sat_pkg.sv @@
// Shared types and constants of the summed area table query block.
package sat_pkg;

	localparam int COORD_W   = 7;
	localparam int QCOORD_W  = 6;
	localparam int ELEM_W    = 16;
	localparam int RUN_W     = 22;
	localparam int ENTRY_W   = 28;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 7;
	localparam int CMD_DEPTH = 2;
	localparam int PTR_W     = 1;
	localparam int CNT_W     = 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_COORD  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INCOMPLETE = 2'd2;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef struct packed {
		logic [1:0]          kind;
		logic [STATUS_W-1:0] status;
		logic [COORD_W-1:0]  bot;
		logic [COORD_W-1:0]  top_m1;
		logic [COORD_W-1:0]  right;
		logic [COORD_W-1:0]  left_m1;
		logic                top_zero;
		logic                left_zero;
		logic [RUN_W-1:0]    run_sum;
	} cmd_t;

endpackage

@@ src/sat_front.sv @@
// Front end: accepts requests, tracks load position and row sum, checks queries.
module sat_front #(
	parameter int MAX_ROWS      = 64,
	parameter int MAX_COLS      = 64,
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           operation,
	input  logic                           restart_load,
	input  logic signed [sat_pkg::ELEM_W-1:0] element_value,
	input  logic [sat_pkg::QCOORD_W-1:0]   top_row,
	input  logic [sat_pkg::QCOORD_W-1:0]   left_col,
	input  logic [sat_pkg::QCOORD_W-1:0]   bottom_row,
	input  logic [sat_pkg::QCOORD_W-1:0]   right_col,
	input  logic                           cfg_we,
	input  logic [sat_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sat_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           cmd_full,
	output logic                           cmd_push,
	output sat_pkg::cmd_t                  cmd
);
	import sat_pkg::*;

	localparam int ROW_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int COL_CAP = (MAX_COLS < 127) ? MAX_COLS : 127;

	logic [COORD_W-1:0] rows_q, cols_q;
	logic [COORD_W-1:0] load_row_q, load_col_q;
	logic [RUN_W-1:0]   run_q;
	logic               complete_q;

	logic [COORD_W-1:0] eff_rows, eff_cols;
	logic [COORD_W-1:0] row_c, col_c, row_n, col_n;
	logic [RUN_W-1:0]   run_c, run_n, elem22;
	logic               complete_n;
	logic [31:0]        ext;
	logic               accept, in_range, bad;
	logic [COORD_W-1:0] top_e, left_e, bot_e, right_e;

	always_comb begin
		eff_rows = (rows_q == '0) ? COORD_W'(1) :
			(rows_q > COORD_W'(ROW_CAP)) ? COORD_W'(ROW_CAP) : rows_q;
		eff_cols = (cols_q == '0) ? COORD_W'(1) :
			(cols_q > COORD_W'(COL_CAP)) ? COORD_W'(COL_CAP) : cols_q;
	end

	always_comb begin
		ext = 32'($unsigned(element_value));
		for (int k = 0; k < RUN_W; k++) begin
			elem22[k] = (k < ELEMENT_WIDTH) ? ext[k] : ext[ELEMENT_WIDTH-1];
		end
	end

	assign accept = push && !cmd_full;

	always_comb begin
		row_c = restart_load ? '0 : load_row_q;
		col_c = restart_load ? '0 : load_col_q;
		run_c = restart_load ? '0 : run_q;
		complete_n = restart_load ? 1'b0 : complete_q;
		in_range = (row_c < eff_rows) && (col_c < eff_cols);
		run_n = run_c + elem22;
		row_n = row_c;
		col_n = col_c;
		if (in_range) begin
			if (col_c + COORD_W'(1) >= eff_cols) begin
				col_n = '0;
				run_n = '0;
				row_n = row_c + COORD_W'(1);
				if (row_c + COORD_W'(1) >= eff_rows) begin
					complete_n = 1'b1;
				end
			end else begin
				col_n = col_c + COORD_W'(1);
			end
		end else begin
			run_n = run_c;
		end
	end

	always_comb begin
		top_e   = COORD_W'(top_row);
		left_e  = COORD_W'(left_col);
		bot_e   = COORD_W'(bottom_row);
		right_e = COORD_W'(right_col);
		bad = (top_e > bot_e) || (left_e > right_e) ||
			(bot_e >= eff_rows) || (right_e >= eff_cols);
	end

	always_comb begin
		cmd = '0;
		cmd_push = 1'b0;
		if (operation == OP_LOAD) begin
			cmd.kind     = KIND_LOAD;
			cmd.bot      = row_c;
			cmd.right    = col_c;
			cmd.top_zero = (row_c == '0);
			cmd.top_m1   = (row_c == '0) ? '0 : row_c - COORD_W'(1);
			cmd.run_sum  = run_c + elem22;
			cmd_push     = accept && in_range;
		end else begin
			cmd_push = accept;
			if (!complete_q) begin
				cmd.kind   = KIND_ERROR;
				cmd.status = STATUS_INCOMPLETE;
			end else if (bad) begin
				cmd.kind   = KIND_ERROR;
				cmd.status = STATUS_BAD_COORD;
			end else begin
				cmd.kind      = KIND_QUERY;
				cmd.status    = STATUS_OK;
				cmd.bot       = bot_e;
				cmd.right     = right_e;
				cmd.top_zero  = (top_e == '0);
				cmd.left_zero = (left_e == '0);
				cmd.top_m1    = (top_e == '0) ? '0 : top_e - COORD_W'(1);
				cmd.left_m1   = (left_e == '0) ? '0 : left_e - COORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= COORD_W'(64);
			cols_q     <= COORD_W'(64);
			load_row_q <= '0;
			load_col_q <= '0;
			run_q      <= '0;
			complete_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_q <= cfg_data;
				REG_COLS: cols_q <= cfg_data;
				default: ;
			endcase
			load_row_q <= '0;
			load_col_q <= '0;
			run_q      <= '0;
			complete_q <= 1'b0;
		end else if (accept && operation == OP_LOAD) begin
			load_row_q <= row_n;
			load_col_q <= col_n;
			run_q      <= run_n;
			complete_q <= complete_n;
		end
	end

endmodule

@@ src/sat_cmd_fifo.sv @@
// Short command queue between the front end and the table engine.
module sat_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  sat_pkg::cmd_t din,
	output logic          full,
	input  logic          rd_en,
	output sat_pkg::cmd_t dout,
	output logic          empty
);
	import sat_pkg::*;

	cmd_t              slot_q [CMD_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr, do_rd;

	assign full  = (count_q == CNT_W'(CMD_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = slot_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ src/sat_back.sv @@
// Table engine: single-port prefix table, load update and four-read query.
module sat_back #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_empty,
	input  sat_pkg::cmd_t                     cmd,
	output logic                              cmd_pop,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [sat_pkg::ENTRY_W-1:0] region_sum,
	output logic [sat_pkg::STATUS_W-1:0]      status
);
	import sat_pkg::*;

	localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOAD   = 2'd1;
	localparam logic [1:0] ST_QUERY  = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	logic [ENTRY_W-1:0] mem [MEM_DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	logic [1:0]          state_q;
	logic [2:0]          step_q;
	cmd_t                cmd_q;
	logic [ENTRY_W-1:0]  acc_q;
	logic [STATUS_W-1:0] stat_q;
	logic                res_valid_q;
	logic [ENTRY_W-1:0]  res_sum_q;
	logic [STATUS_W-1:0] res_status_q;

	logic [COORD_W-1:0] row_sel, col_sel;
	logic [ADDR_W-1:0]  mem_addr;
	logic               mem_we;
	logic [ENTRY_W-1:0] mem_wdata, term, above;
	logic               term_zero, slot_free;

	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign slot_free = !res_valid_q || pop;

	always_comb begin
		row_sel = cmd_q.bot;
		col_sel = cmd_q.right;
		mem_we  = 1'b0;
		if (state_q == ST_LOAD) begin
			if (step_q == 3'd0) begin
				row_sel = cmd_q.top_m1;
			end else begin
				mem_we = 1'b1;
			end
		end else if (state_q == ST_QUERY) begin
			case (step_q)
				3'd1: row_sel = cmd_q.top_m1;
				3'd2: col_sel = cmd_q.left_m1;
				3'd3: begin
					row_sel = cmd_q.top_m1;
					col_sel = cmd_q.left_m1;
				end
				default: ;
			endcase
		end
		mem_addr = ADDR_W'(32'(row_sel) * 32'(MAX_COLS) + 32'(col_sel));
	end

	always_comb begin
		above     = cmd_q.top_zero ? '0 : rd_q;
		mem_wdata = above + ENTRY_W'($signed(cmd_q.run_sum));
		case (step_q)
			3'd2:    term_zero = cmd_q.top_zero;
			3'd3:    term_zero = cmd_q.left_zero;
			3'd4:    term_zero = cmd_q.top_zero || cmd_q.left_zero;
			default: term_zero = 1'b0;
		endcase
		term = term_zero ? '0 : rd_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q  <= cmd;
			acc_q  <= '0;
			stat_q <= cmd.status;
		end else if (state_q == ST_QUERY) begin
			case (step_q)
				3'd1:       acc_q <= term;
				3'd2, 3'd3: acc_q <= acc_q - term;
				3'd4:       acc_q <= acc_q + term;
				default: ;
			endcase
		end
		if (state_q == ST_RESULT && slot_free) begin
			res_sum_q    <= acc_q;
			res_status_q <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESULT && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (!cmd_empty) begin
						case (cmd.kind)
							KIND_LOAD:  state_q <= ST_LOAD;
							KIND_QUERY: state_q <= ST_QUERY;
							default:    state_q <= ST_RESULT;
						endcase
					end
				end
				ST_LOAD: begin
					step_q <= step_q + 3'd1;
					if (step_q != 3'd0) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QUERY: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty      = !res_valid_q;
	assign region_sum = res_sum_q;
	assign status     = res_status_q;

endmodule

@@ src/summed_area_table_query.sv @@
// Top level of the summed area table query block.
// A load request takes the table engine through its idle, read above and write states.
// A query takes it through idle, four reads through one registered port, and result.
// A flagged query goes from idle straight to result, without the four reads.
// Throughput is set by the single-port table memory; a two-deep queue decouples the front.
// Reset clears control state and the load position; table contents stay undefined.
module summed_area_table_query #(
	parameter int MAX_ROWS      = 64,
	parameter int MAX_COLS      = 64,
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               operation,
	input  logic                               restart_load,
	input  logic signed [sat_pkg::ELEM_W-1:0]  element_value,
	input  logic [sat_pkg::QCOORD_W-1:0]       top_row,
	input  logic [sat_pkg::QCOORD_W-1:0]       left_col,
	input  logic [sat_pkg::QCOORD_W-1:0]       bottom_row,
	input  logic [sat_pkg::QCOORD_W-1:0]       right_col,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [sat_pkg::ENTRY_W-1:0] region_sum,
	output logic [sat_pkg::STATUS_W-1:0]       status,
	input  logic                               cfg_we,
	input  logic [sat_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sat_pkg::CFG_W-1:0]          cfg_data
);
	import sat_pkg::*;

	cmd_t cmd_in, cmd_out;
	logic cmd_push, cmd_full, cmd_pop, cmd_empty;

	sat_front #(
		.MAX_ROWS      (MAX_ROWS),
		.MAX_COLS      (MAX_COLS),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.operation     (operation),
		.restart_load  (restart_load),
		.element_value (element_value),
		.top_row       (top_row),
		.left_col      (left_col),
		.bottom_row    (bottom_row),
		.right_col     (right_col),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd_full      (cmd_full),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in)
	);

	sat_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.rd_en  (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	sat_back #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_empty  (cmd_empty),
		.cmd        (cmd_out),
		.cmd_pop    (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.region_sum (region_sum),
		.status     (status)
	);

	assign full = cmd_full;

	a_err_sum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != STATUS_OK) |-> (region_sum == '0))
		else $error("error result carries a nonzero sum");

	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_full && cmd_empty))
		else $error("command queue both full and empty");

	a_full_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd_full) |-> $past(cmd_push))
		else $error("command queue filled without a request");

endmodule

@@ test/summed_area_table_query_tb.sv @@
// Self-checking testbench for the summed area table query block.
module summed_area_table_query_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import sat_pkg::*;

	localparam int SAT_MAX       = 64;
	localparam int RANDOM_TARGET = 600;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic                       op;
		logic                       restart;
		logic signed [ELEM_W-1:0]   elem;
		logic [QCOORD_W-1:0]        top;
		logic [QCOORD_W-1:0]        left;
		logic [QCOORD_W-1:0]        bottom;
		logic [QCOORD_W-1:0]        right;
	} sat_request_t;

	typedef struct packed {
		logic [ENTRY_W-1:0]  sum;
		logic [STATUS_W-1:0] code;
	} region_answer_t;

	typedef struct {
		bit                   is_write;
		logic [CFG_IDX_W-1:0] reg_sel;
		logic [CFG_W-1:0]     reg_val;
		sat_request_t         rq;
		bit                   known;
		region_answer_t       answer;
	} script_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        push;
	logic                        full;
	logic                        operation;
	logic                        restart_load;
	logic signed [ELEM_W-1:0]    element_value;
	logic [QCOORD_W-1:0]         top_row;
	logic [QCOORD_W-1:0]         left_col;
	logic [QCOORD_W-1:0]         bottom_row;
	logic [QCOORD_W-1:0]         right_col;
	logic                        empty;
	logic                        pop;
	logic signed [ENTRY_W-1:0]   region_sum;
	logic [STATUS_W-1:0]         status;
	logic                        cfg_we;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]            cfg_data;

	// answer typed into the script for the request currently offered
	logic                        known_now;
	region_answer_t              known_answer;

	// predictor state
	logic [ENTRY_W-1:0]          prefix_sums [SAT_MAX*SAT_MAX];
	logic signed [RUN_W-1:0]     row_acc = '0;
	logic [COORD_W-1:0]          fill_row = '0;
	logic [QCOORD_W-1:0]         fill_col = '0;
	logic                        table_ready = 1'b0;
	logic [CFG_W-1:0]            cfg_rows = 7'd64;
	logic [CFG_W-1:0]            cfg_cols = 7'd64;

	region_answer_t              expected_answers [$];
	script_row_t                 script [$];
	int                          mismatches = 0;
	int                          requests_done = 0;
	int                          send_idle_pct = 31;
	int                          recv_idle_pct = 45;
	bit                          hold_req = 1'b0;
	int                          rows_raw = 64;
	int                          cols_raw = 64;

	summed_area_table_query uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.restart_load  (restart_load),
		.element_value (element_value),
		.top_row       (top_row),
		.left_col      (left_col),
		.bottom_row    (bottom_row),
		.right_col     (right_col),
		.empty         (empty),
		.pop           (pop),
		.region_sum    (region_sum),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int clamp_dim(int v);
		if (v < 1) return 1;
		if (v > SAT_MAX) return SAT_MAX;
		return v;
	endfunction

	function automatic logic [ENTRY_W-1:0] table_entry(int i, int j);
		if (i == 0 || j == 0) return '0;
		return prefix_sums[(i - 1) * SAT_MAX + (j - 1)];
	endfunction

	function automatic void clear_fill();
		fill_row = '0;
		fill_col = '0;
		row_acc = '0;
		table_ready = 1'b0;
	endfunction

	function automatic region_answer_t predict_region_sum(sat_request_t rq);
		region_answer_t ans;
		int n_rows;
		int n_cols;
		logic signed [ENTRY_W-1:0] acc_wide;
		ans.sum = '0;
		ans.code = STATUS_OK;
		n_rows = clamp_dim(cfg_rows);
		n_cols = clamp_dim(cfg_cols);
		if (rq.op == OP_LOAD) begin
			if (rq.restart) clear_fill();
			if (fill_row < n_rows && fill_col < n_cols) begin
				row_acc = row_acc + $signed(rq.elem);
				acc_wide = row_acc;
				prefix_sums[fill_row * SAT_MAX + fill_col] =
					table_entry(fill_row, fill_col + 1) + acc_wide;
				if (fill_col + 1 >= n_cols) begin
					fill_col = '0;
					row_acc = '0;
					fill_row = fill_row + 1'b1;
					if (fill_row >= n_rows) table_ready = 1'b1;
				end else begin
					fill_col = fill_col + 1'b1;
				end
			end
		end else if (!table_ready) begin
			ans.code = STATUS_INCOMPLETE;
		end else if (rq.top > rq.bottom || rq.left > rq.right ||
				rq.bottom >= n_rows || rq.right >= n_cols) begin
			ans.code = STATUS_BAD_COORD;
		end else begin
			ans.sum = table_entry(rq.bottom + 1, rq.right + 1) - table_entry(rq.top, rq.right + 1)
				- table_entry(rq.bottom + 1, rq.left) + table_entry(rq.top, rq.left);
		end
		return ans;
	endfunction

	always @(posedge clk) begin : watch
		region_answer_t calc;
		region_answer_t want;
		if (cfg_we) begin
			if (cfg_index == REG_ROWS) cfg_rows = cfg_data;
			else cfg_cols = cfg_data;
			clear_fill();
		end
		if (push && !full) begin
			calc = predict_region_sum({operation, restart_load, element_value,
				top_row, left_col, bottom_row, right_col});
			if (operation == OP_QUERY) expected_answers.push_back(known_now ? known_answer : calc);
		end
		if (pop && !empty) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result, expected none, got region_sum %0d status %0d",
					$time, region_sum, status);
				mismatches++;
			end else begin
				want = expected_answers.pop_front();
				if (status !== want.code) begin
					$display("%0t: status expected %0d got %0d", $time, want.code, status);
					mismatches++;
				end
				if (region_sum !== want.sum) begin
					$display("%0t: region_sum expected %0d got %0d", $time,
						$signed(want.sum), region_sum);
					mismatches++;
				end
			end
		end
	end

	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			pop <= ($urandom_range(0, 99) < recv_idle_pct) ? 1'b0 : 1'b1;
		end
	end

	function automatic sat_request_t load_req(logic rs, int v);
		sat_request_t rq;
		rq.op = OP_LOAD;
		rq.restart = rs;
		rq.elem = ELEM_W'(v);
		rq.top = QCOORD_W'($urandom);
		rq.left = QCOORD_W'($urandom);
		rq.bottom = QCOORD_W'($urandom);
		rq.right = QCOORD_W'($urandom);
		return rq;
	endfunction

	function automatic sat_request_t query_req(int t, int l, int b, int r);
		sat_request_t rq;
		rq.op = OP_QUERY;
		rq.restart = 1'($urandom);
		rq.elem = ELEM_W'($urandom);
		rq.top = QCOORD_W'(t);
		rq.left = QCOORD_W'(l);
		rq.bottom = QCOORD_W'(b);
		rq.right = QCOORD_W'(r);
		return rq;
	endfunction

	function automatic int pick_elem();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic void script_req(sat_request_t rq);
		script_row_t row;
		row.is_write = 1'b0;
		row.reg_sel = REG_ROWS;
		row.reg_val = '0;
		row.rq = rq;
		row.known = 1'b0;
		row.answer = '0;
		script.push_back(row);
	endfunction

	function automatic void script_known(sat_request_t rq, int ksum, logic [STATUS_W-1:0] kcode);
		script_row_t row;
		row.is_write = 1'b0;
		row.reg_sel = REG_ROWS;
		row.reg_val = '0;
		row.rq = rq;
		row.known = 1'b1;
		row.answer.sum = ENTRY_W'(ksum);
		row.answer.code = kcode;
		script.push_back(row);
	endfunction

	function automatic void script_cfg(logic [CFG_IDX_W-1:0] sel, int v);
		script_row_t row;
		row.is_write = 1'b1;
		row.reg_sel = sel;
		row.reg_val = CFG_W'(v);
		row.rq = '0;
		row.known = 1'b0;
		row.answer = '0;
		script.push_back(row);
	endfunction

	task automatic offer(sat_request_t rq, bit known, region_answer_t answer, bit counts);
		if (requests_done < 200) begin
			send_idle_pct = 31;
			recv_idle_pct = 45;
		end else if (requests_done < 400) begin
			send_idle_pct = 45;
			recv_idle_pct = 31;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		operation <= rq.op;
		restart_load <= rq.restart;
		element_value <= rq.elem;
		top_row <= rq.top;
		left_col <= rq.left;
		bottom_row <= rq.bottom;
		right_col <= rq.right;
		known_now <= known;
		known_answer <= answer;
		@(posedge clk);
		while (full) @(posedge clk);
		if (counts) requests_done++;
	endtask

	// sender pause: wait for every pending result, then let queued loads finish
	task automatic settle_block();
		push <= 1'b0;
		@(posedge clk);
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] sel, int v);
		if (sel == REG_ROWS) rows_raw = v;
		else cols_raw = v;
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= CFG_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(int phase);
		int rows_w;
		int cols_w;
		int n_rows;
		int n_cols;
		int total;
		int idx;
		int n_q;
		int pick;
		int t;
		int b;
		int l;
		int r;
		bit partial;
		bit restarted;
		case (phase)
			0: begin
				rows_w = 1;
				cols_w = 64;
			end
			1: begin
				rows_w = 64;
				cols_w = 1;
			end
			2: begin
				rows_w = 127;
				cols_w = 2;
			end
			3: begin
				rows_w = 0;
				cols_w = 6;
			end
			default: begin
				rows_w = $urandom_range(1, 8);
				cols_w = $urandom_range(1, 8);
			end
		endcase
		settle_block();
		if (phase > 3 && $urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 1)) write_reg(REG_ROWS, rows_w);
			else write_reg(REG_COLS, cols_w);
		end else begin
			write_reg(REG_ROWS, rows_w);
			write_reg(REG_COLS, cols_w);
		end
		n_rows = clamp_dim(rows_raw);
		n_cols = clamp_dim(cols_raw);
		total = n_rows * n_cols;
		partial = (phase > 3) && ($urandom_range(0, 7) == 0);
		if (partial) total = $urandom_range(1, total);
		idx = 0;
		restarted = 1'b0;
		while (idx < total) begin
			if ($urandom_range(0, 11) == 0) begin
				offer(query_req($urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 63)), 1'b0, '0, 1'b1);
			end else if (idx > 0 && !restarted && $urandom_range(0, 49) == 0) begin
				offer(load_req(1'b1, pick_elem()), 1'b0, '0, 1'b1);
				restarted = 1'b1;
				idx = 1;
			end else begin
				offer(load_req(idx == 0 && $urandom_range(0, 1), pick_elem()), 1'b0, '0, 1'b1);
				idx++;
			end
		end
		if (partial) return;
		n_q = $urandom_range(6, 24);
		if (phase == 0) begin
			hold_req = 1'b1;
			n_q = 30;
		end
		repeat (n_q) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				t = $urandom_range(0, n_rows - 1);
				b = $urandom_range(t, n_rows - 1);
				l = $urandom_range(0, n_cols - 1);
				r = $urandom_range(l, n_cols - 1);
				offer(query_req(t, l, b, r), 1'b0, '0, 1'b1);
			end else if (pick < 92) begin
				offer(query_req($urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 63)), 1'b0, '0, 1'b1);
			end else if (pick < 98) begin
				offer(load_req(1'b0, pick_elem()), 1'b0, '0, 1'b0);
			end else begin
				offer(load_req(1'b1, pick_elem()), 1'b0, '0, 1'b1);
			end
		end
	endtask

	initial begin
		push <= 1'b0;
		operation <= OP_LOAD;
		restart_load <= 1'b0;
		element_value <= '0;
		top_row <= '0;
		left_col <= '0;
		bottom_row <= '0;
		right_col <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ROWS;
		cfg_data <= '0;
		known_now <= 1'b0;
		known_answer <= '0;
		arst_n <= 1'b0;

		script_known(query_req(0, 0, 0, 0), 0, STATUS_INCOMPLETE);
		script_cfg(REG_ROWS, 2);
		script_cfg(REG_COLS, 3);
		script_req(load_req(1'b1, -32768));
		script_req(load_req(1'b0, 32767));
		script_req(load_req(1'b0, -1));
		script_known(query_req(0, 0, 0, 0), 0, STATUS_INCOMPLETE);
		script_req(load_req(1'b0, 1));
		script_req(load_req(1'b0, 0));
		script_req(load_req(1'b0, -32768));
		// table full: this load is dropped
		script_req(load_req(1'b0, 32767));
		script_req(query_req(0, 0, 1, 2));
		script_req(query_req(1, 2, 1, 2));
		script_req(query_req(0, 1, 1, 1));
		script_known(query_req(1, 0, 0, 0), 0, STATUS_BAD_COORD);
		script_known(query_req(0, 2, 0, 1), 0, STATUS_BAD_COORD);
		script_known(query_req(0, 0, 2, 0), 0, STATUS_BAD_COORD);
		script_known(query_req(0, 0, 0, 3), 0, STATUS_BAD_COORD);
		script_known(query_req(63, 63, 63, 63), 0, STATUS_BAD_COORD);
		script_req(load_req(1'b1, 5));
		script_known(query_req(0, 0, 0, 0), 0, STATUS_INCOMPLETE);
		// zero sizes saturate to a 1x1 matrix
		script_cfg(REG_ROWS, 0);
		script_cfg(REG_COLS, 0);
		script_req(load_req(1'b0, -32768));
		script_known(query_req(0, 0, 0, 0), -32768, STATUS_OK);
		script_req(load_req(1'b1, 32767));
		script_known(query_req(0, 0, 0, 0), 32767, STATUS_OK);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_write) begin
				settle_block();
				write_reg(script[i].reg_sel, script[i].reg_val);
			end else begin
				offer(script[i].rq, script[i].known, script[i].answer, 1'b0);
			end
		end

		for (int phase = 0; requests_done < RANDOM_TARGET; phase++) run_phase(phase);

		settle_block();
		if (mismatches == 0 && expected_answers.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#(2_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
src/sat_pkg.sv
src/sat_front.sv
src/sat_cmd_fifo.sv
src/sat_back.sv
src/summed_area_table_query.sv
test/summed_area_table_query_tb.sv
